@@ design/sbhs_pkg.sv @@
package sbhs_pkg;

   localparam int PhaseWidth = 5;

   localparam logic [PhaseWidth-1:0] PH_IDLE      = 5'd0;
   localparam logic [PhaseWidth-1:0] PH_SYNC_POLL = 5'd1;
   localparam logic [PhaseWidth-1:0] PH_ACK_ZERO  = 5'd2;
   localparam logic [PhaseWidth-1:0] PH_ACK_POLL  = 5'd3;
   localparam logic [PhaseWidth-1:0] PH_ACK_END   = 5'd4;
   localparam logic [PhaseWidth-1:0] PH_HDR_FRAME = 5'd5;
   localparam logic [PhaseWidth-1:0] PH_HDR_CODE  = 5'd6;
   localparam logic [PhaseWidth-1:0] PH_HDR_CHK   = 5'd7;
   localparam logic [PhaseWidth-1:0] PH_ADDR      = 5'd8;
   localparam logic [PhaseWidth-1:0] PH_ADDR_CHK  = 5'd9;
   localparam logic [PhaseWidth-1:0] PH_LEN       = 5'd10;
   localparam logic [PhaseWidth-1:0] PH_LEN_CHK   = 5'd11;
   localparam logic [PhaseWidth-1:0] PH_RD_LEAD   = 5'd12;
   localparam logic [PhaseWidth-1:0] PH_RD_DATA   = 5'd13;
   localparam logic [PhaseWidth-1:0] PH_GET_LEAD  = 5'd14;
   localparam logic [PhaseWidth-1:0] PH_GET_LEN   = 5'd15;
   localparam logic [PhaseWidth-1:0] PH_GET_DATA  = 5'd16;
   localparam logic [PhaseWidth-1:0] PH_WR_LEN    = 5'd17;
   localparam logic [PhaseWidth-1:0] PH_WR_DATA   = 5'd18;
   localparam logic [PhaseWidth-1:0] PH_WR_CHK    = 5'd19;
   localparam logic [PhaseWidth-1:0] PH_ER_FF1    = 5'd20;
   localparam logic [PhaseWidth-1:0] PH_ER_FF2    = 5'd21;
   localparam logic [PhaseWidth-1:0] PH_ER_CHK    = 5'd22;

   localparam logic [2:0] CMD_SYNC  = 3'd0;
   localparam logic [2:0] CMD_GET   = 3'd1;
   localparam logic [2:0] CMD_READ  = 3'd2;
   localparam logic [2:0] CMD_WRMEM = 3'd3;
   localparam logic [2:0] CMD_ERASE = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_UNEXP = 2'd1;
   localparam logic [1:0] ST_NACK  = 2'd2;
   localparam logic [1:0] ST_TOUT  = 2'd3;

   localparam logic [7:0] B_DUMMY = 8'hA5;
   localparam logic [7:0] B_FRAME = 8'h5A;
   localparam logic [7:0] B_ACK   = 8'h79;
   localparam logic [7:0] B_NACK  = 8'h1F;
   localparam logic [7:0] B_ZERO  = 8'h00;
   localparam logic [7:0] B_ONES  = 8'hFF;

   localparam logic [15:0] POLL_LIMIT_RESET = 16'd4096;

   typedef struct packed {
      logic        kind;
      logic [2:0]  command;
      logic [31:0] address;
      logic [7:0]  count_m1;
      logic [7:0]  rx_byte;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_valid;
      logic       payload_wanted;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [2:0]            active_command;
      logic [31:0]           target_address;
      logic [7:0]            byte_counter;
      logic [7:0]            length_held;
      logic [7:0]            xor_accumulator;
      logic [15:0]           poll_counter;
      logic [PhaseWidth-1:0] return_phase;
   } state_type;

   function automatic logic [7:0] opcode_byte(input logic [2:0] cmd);
      logic [7:0] c;
      unique case (cmd)
         CMD_READ:  c = 8'h11;
         CMD_WRMEM: c = 8'h31;
         CMD_ERASE: c = 8'h44;
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] addr_byte(input logic [31:0] a, input logic [1:0] k);
      logic [7:0] b;
      unique case (k)
         2'd0: b = a[31:24];
         2'd1: b = a[23:16];
         2'd2: b = a[15:8];
         default: b = a[7:0];
      endcase
      return b;
   endfunction

endpackage

@@ design/sbhs_req_if.sv @@
interface sbhs_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  command;
   logic [31:0] address;
   logic [7:0]  count_m1;
   logic [7:0]  rx_byte;
   logic [7:0]  payload_byte;

   modport source (output valid, kind, command, address, count_m1, rx_byte, payload_byte,
                   input ready);
   modport sink (input valid, kind, command, address, count_m1, rx_byte, payload_byte,
                 output ready);
endinterface

@@ design/sbhs_rsp_if.sv @@
interface sbhs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_valid;
   logic       payload_wanted;
   logic       read_valid;
   logic [7:0] read_byte;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, tx_byte, tx_valid, payload_wanted, read_valid, read_byte,
                   done_res, status, input ready);
   modport sink (input valid, tx_byte, tx_valid, payload_wanted, read_valid, read_byte,
                 done_res, status, output ready);
endinterface

@@ design/sbhs_step.sv @@
module sbhs_step
   import sbhs_pkg::*;
(
   input  state_type  st,
   input  req_type    item,
   input  logic [15:0] poll_limit,
   output state_type  st_next,
   output rsp_type    rsp
);

   logic [7:0] bc_inc;
   logic [7:0] next_addr;

   assign bc_inc    = st.byte_counter + 8'd1;
   assign next_addr = addr_byte(st.target_address, bc_inc[1:0]);

   always_comb begin
      st_next = st;
      rsp     = '0;
      if (!item.kind) begin
         // start beat: latch the command and reset the counters
         st_next.active_command  = item.command;
         st_next.target_address  = item.address;
         st_next.length_held     = item.count_m1;
         st_next.byte_counter    = '0;
         st_next.xor_accumulator = '0;
         st_next.poll_counter    = '0;
         st_next.return_phase    = PH_IDLE;
         if (item.command == CMD_SYNC) begin
            st_next.poll_counter = 16'd1;
            rsp.tx_byte = B_FRAME; rsp.tx_valid = 1'b1; st_next.phase = PH_SYNC_POLL;
         end else if (item.command <= CMD_ERASE) begin
            rsp.tx_byte = B_FRAME; rsp.tx_valid = 1'b1; st_next.phase = PH_HDR_FRAME;
         end else begin
            rsp.done_res = 1'b1; rsp.status = ST_UNEXP; st_next.phase = PH_IDLE;
         end
      end else begin
         unique case (st.phase)
            PH_SYNC_POLL: begin
               if (item.rx_byte == B_DUMMY) begin
                  st_next.return_phase = PH_IDLE;
                  rsp.tx_byte = B_ZERO; rsp.tx_valid = 1'b1; st_next.phase = PH_ACK_ZERO;
               end else begin
                  rsp.done_res = 1'b1;
                  rsp.status   = (item.rx_byte == B_NACK) ? ST_NACK : ST_UNEXP;
                  st_next.phase = PH_IDLE;
               end
            end
            PH_ACK_ZERO: begin
               if (item.rx_byte == B_DUMMY) begin
                  st_next.poll_counter = 16'd1;
                  rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1; st_next.phase = PH_ACK_POLL;
               end else begin
                  rsp.done_res = 1'b1; rsp.status = ST_UNEXP; st_next.phase = PH_IDLE;
               end
            end
            PH_ACK_POLL: begin
               if (item.rx_byte == B_ACK) begin
                  rsp.tx_byte = B_ACK; rsp.tx_valid = 1'b1; st_next.phase = PH_ACK_END;
               end else if (item.rx_byte == B_DUMMY) begin
                  if (st.poll_counter >= poll_limit) begin
                     rsp.done_res = 1'b1; rsp.status = ST_TOUT; st_next.phase = PH_IDLE;
                  end else begin
                     st_next.poll_counter = st.poll_counter + 16'd1;
                     rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1;
                     st_next.phase = PH_ACK_POLL;
                  end
               end else begin
                  rsp.done_res = 1'b1;
                  rsp.status   = (item.rx_byte == B_NACK) ? ST_NACK : ST_UNEXP;
                  st_next.phase = PH_IDLE;
               end
            end
            PH_ACK_END: begin
               if (item.rx_byte != B_DUMMY) begin
                  rsp.done_res = 1'b1; rsp.status = ST_UNEXP; st_next.phase = PH_IDLE;
               end else begin
                  // ack complete: resume after the phase that asked for it
                  unique case (st.return_phase)
                     PH_HDR_CHK: begin
                        if (st.active_command == CMD_GET) begin
                           rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1;
                           st_next.phase = PH_GET_LEAD;
                        end else if (st.active_command == CMD_READ ||
                                     st.active_command == CMD_WRMEM) begin
                           st_next.byte_counter    = '0;
                           st_next.xor_accumulator = st.target_address[31:24];
                           rsp.tx_byte = st.target_address[31:24]; rsp.tx_valid = 1'b1;
                           st_next.phase = PH_ADDR;
                        end else if (st.active_command == CMD_ERASE) begin
                           rsp.tx_byte = B_ONES; rsp.tx_valid = 1'b1;
                           st_next.phase = PH_ER_FF1;
                        end else begin
                           rsp.done_res = 1'b1; rsp.status = ST_OK; st_next.phase = PH_IDLE;
                        end
                     end
                     PH_ADDR_CHK: begin
                        if (st.active_command == CMD_READ) begin
                           rsp.tx_byte = st.length_held; rsp.tx_valid = 1'b1;
                           st_next.phase = PH_LEN;
                        end else if (st.active_command == CMD_WRMEM) begin
                           st_next.xor_accumulator = st.length_held;
                           rsp.tx_byte = st.length_held; rsp.tx_valid = 1'b1;
                           rsp.payload_wanted = 1'b1;
                           st_next.phase = PH_WR_LEN;
                        end else begin
                           rsp.done_res = 1'b1; rsp.status = ST_OK; st_next.phase = PH_IDLE;
                        end
                     end
                     PH_LEN_CHK: begin
                        rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1;
                        st_next.phase = PH_RD_LEAD;
                     end
                     PH_ER_FF2: begin
                        rsp.tx_byte = B_ZERO; rsp.tx_valid = 1'b1;
                        st_next.phase = PH_ER_CHK;
                     end
                     default: begin
                        rsp.done_res = 1'b1; rsp.status = ST_OK; st_next.phase = PH_IDLE;
                     end
                  endcase
               end
            end
            PH_HDR_FRAME: begin
               rsp.tx_byte = opcode_byte(st.active_command); rsp.tx_valid = 1'b1;
               st_next.phase = PH_HDR_CODE;
            end
            PH_HDR_CODE: begin
               rsp.tx_byte = ~opcode_byte(st.active_command); rsp.tx_valid = 1'b1;
               st_next.phase = PH_HDR_CHK;
            end
            PH_HDR_CHK, PH_ADDR_CHK, PH_LEN_CHK, PH_ER_FF2: begin
               st_next.return_phase = st.phase;
               rsp.tx_byte = B_ZERO; rsp.tx_valid = 1'b1; st_next.phase = PH_ACK_ZERO;
            end
            PH_WR_CHK, PH_ER_CHK: begin
               st_next.return_phase = PH_IDLE;
               rsp.tx_byte = B_ZERO; rsp.tx_valid = 1'b1; st_next.phase = PH_ACK_ZERO;
            end
            PH_ADDR: begin
               if (st.byte_counter < 8'd3) begin
                  st_next.byte_counter    = bc_inc;
                  st_next.xor_accumulator = st.xor_accumulator ^ next_addr;
                  rsp.tx_byte = next_addr; rsp.tx_valid = 1'b1; st_next.phase = PH_ADDR;
               end else begin
                  rsp.tx_byte = st.xor_accumulator; rsp.tx_valid = 1'b1;
                  st_next.phase = PH_ADDR_CHK;
               end
            end
            PH_LEN: begin
               rsp.tx_byte = ~st.length_held; rsp.tx_valid = 1'b1;
               st_next.phase = PH_LEN_CHK;
            end
            PH_RD_LEAD: begin
               st_next.byte_counter = '0;
               rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1; st_next.phase = PH_RD_DATA;
            end
            PH_GET_LEN: begin
               st_next.length_held  = item.rx_byte;
               st_next.byte_counter = '0;
               rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1; st_next.phase = PH_GET_DATA;
            end
            PH_GET_LEAD: begin
               rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1; st_next.phase = PH_GET_LEN;
            end
            PH_RD_DATA, PH_GET_DATA: begin
               rsp.read_valid = 1'b1;
               rsp.read_byte  = item.rx_byte;
               if (st.byte_counter >= st.length_held) begin
                  if (st.phase == PH_GET_DATA) begin
                     st_next.return_phase = PH_IDLE;
                     rsp.tx_byte = B_ZERO; rsp.tx_valid = 1'b1;
                     st_next.phase = PH_ACK_ZERO;
                  end else begin
                     rsp.done_res = 1'b1; rsp.status = ST_OK; st_next.phase = PH_IDLE;
                  end
               end else begin
                  st_next.byte_counter = bc_inc;
                  rsp.tx_byte = B_DUMMY; rsp.tx_valid = 1'b1; st_next.phase = st.phase;
               end
            end
            PH_WR_LEN: begin
               st_next.byte_counter    = '0;
               st_next.xor_accumulator = st.xor_accumulator ^ item.payload_byte;
               rsp.tx_byte = item.payload_byte; rsp.tx_valid = 1'b1;
               rsp.payload_wanted = (st.length_held != 8'd0);
               st_next.phase = PH_WR_DATA;
            end
            PH_WR_DATA: begin
               if (st.byte_counter < st.length_held) begin
                  st_next.byte_counter    = bc_inc;
                  st_next.xor_accumulator = st.xor_accumulator ^ item.payload_byte;
                  rsp.tx_byte = item.payload_byte; rsp.tx_valid = 1'b1;
                  rsp.payload_wanted = (bc_inc < st.length_held);
                  st_next.phase = PH_WR_DATA;
               end else begin
                  rsp.tx_byte = st.xor_accumulator; rsp.tx_valid = 1'b1;
                  st_next.phase = PH_WR_CHK;
               end
            end
            PH_ER_FF1: begin
               rsp.tx_byte = B_ONES; rsp.tx_valid = 1'b1; st_next.phase = PH_ER_FF2;
            end
            default: begin
               st_next.phase = PH_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/spi_bootloader_host_sequencer.sv @@
// Host-side byte sequencer for an SPI bootloader. Send a start beat (kind 0) with the
// command, and for read or write the address and length minus one; each result beat
// names the next byte to shift out (tx_valid) and whether the following exchange beat
// must carry a write data byte (payload_wanted). Feed back every completed SPI exchange
// as an exchange beat (kind 1) with the byte received; returned data bytes appear as
// read_valid/read_byte, and the beat that ends the command carries done_res and status
// (ok, unexpected byte, nack, timeout). Ack waits poll at most csr_wdata exchanges, as
// last written (4096 after reset); write it only while no command is running.
// Every beat gives exactly one result beat. Throughput is one beat per clock while the
// result side keeps taking results; a beat passes the input register and the result
// register around the single pass of next-state logic. Exchange beats that arrive while
// idle give an all-zero result, and a start beat during a command drops that command.
module spi_bootloader_host_sequencer
   import sbhs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sbhs_req_if.sink      req_ch,
   sbhs_rsp_if.source    rsp_ch,
   input  logic          csr_we,
   input  logic [15:0]   csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   state_type   st_ff, st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [15:0] poll_limit_ff;
   logic        advance;
   logic        take_req;
   req_type     req_item;

   // Gather the inbound beat into one word.
   assign req_item.kind         = req_ch.kind;
   assign req_item.command      = req_ch.command;
   assign req_item.address      = req_ch.address;
   assign req_item.count_m1     = req_ch.count_m1;
   assign req_item.rx_byte      = req_ch.rx_byte;
   assign req_item.payload_byte = req_ch.payload_byte;

   // Advance the held beat whenever the result slot is free or being emptied.
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take_req     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = take_req || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   sbhs_step u_step (
      .st         (st_ff),
      .item       (in_ff),
      .poll_limit (poll_limit_ff),
      .st_next    (st_in),
      .rsp        (rsp_in)
   );

   // Control state and the poll limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         st_ff         <= '0;
         poll_limit_ff <= POLL_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
         if (csr_we) begin
            poll_limit_ff <= csr_wdata;
         end
      end
   end

   // Payload registers: hold until the next beat moves in.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_ff <= req_item;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tx_byte        = rsp_ff.tx_byte;
   assign rsp_ch.tx_valid       = rsp_ff.tx_valid;
   assign rsp_ch.payload_wanted = rsp_ff.payload_wanted;
   assign rsp_ch.read_valid     = rsp_ff.read_valid;
   assign rsp_ch.read_byte      = rsp_ff.read_byte;
   assign rsp_ch.done_res       = rsp_ff.done_res;
   assign rsp_ch.status         = rsp_ff.status;

   // A beat that ends the command leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.done_res) |=> (st_ff.phase == PH_IDLE))
      else $error("command ended but phase not idle");

   // Exchange beats while idle produce nothing.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.kind && st_ff.phase == PH_IDLE) |-> (rsp_in == '0))
      else $error("idle exchange produced a result");

   // A payload request only ever leads into the write length or write data phase.
   a_pw_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_in.payload_wanted) |=>
         (st_ff.phase == PH_WR_LEN || st_ff.phase == PH_WR_DATA))
      else $error("payload requested outside write data");

   // With the result slot empty the block must take a new beat.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("stalled with free result slot");

endmodule

@@ verif/spi_bootloader_host_sequencer_test.sv @@
`timescale 1ns / 1ps

module spi_bootloader_host_sequencer_test;
   import sbhs_pkg::*;

   // Beat kinds on the request channel
   localparam logic KIND_START    = 1'b0;
   localparam logic KIND_EXCHANGE = 1'b1;

   // Header codes as the host puts them on the wire
   localparam logic [7:0] HDR_SYNC_GET = 8'h00;
   localparam logic [7:0] HDR_READ     = 8'h11;
   localparam logic [7:0] HDR_WRITE    = 8'h31;
   localparam logic [7:0] HDR_ERASE    = 8'h44;

   localparam int MAX_GAP        = 12;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [15:0] csr_wdata;

   sbhs_req_if req_ch ();
   sbhs_rsp_if rsp_ch ();

   spi_bootloader_host_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Shadow copy of the sequencer: configuration and conversation state
   // ------------------------------------------------------------------
   logic [15:0]           poll_limit_q;
   logic [PhaseWidth-1:0] seq_phase;
   logic [PhaseWidth-1:0] ack_return_phase;
   logic [2:0]            cur_cmd;
   logic [31:0]           cur_addr;
   logic [8:0]            byte_cnt;
   logic [7:0]            len_q;
   logic [7:0]            xsum;
   logic [15:0]           poll_cnt;
   rsp_type               next_rsp;

   // Responses predicted at request acceptance, oldest first
   rsp_type pending_responses [$];

   int fail_count      = 0;
   int beats_sent      = 0;  // beats that the sequencer acts upon
   int rsp_hold_cycles = 0;  // one-off long back-pressure request for the receiver
   bit no_gaps         = 1'b0;
   int poll_dummy_pct  = 60; // share of ack polls answered with the dummy byte

   function automatic int draw_gap();
      return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic logic [7:0] header_code(input logic [2:0] cmd);
      logic [7:0] code;
      case (cmd)
         CMD_READ:  code = HDR_READ;
         CMD_WRMEM: code = HDR_WRITE;
         CMD_ERASE: code = HDR_ERASE;
         default:   code = HDR_SYNC_GET;
      endcase
      return code;
   endfunction

   // Address goes out most significant byte first
   function automatic logic [7:0] address_byte_at(input int k);
      return cur_addr[(3 - k) * 8 +: 8];
   endfunction

   function automatic void send_next(input logic [7:0] b, input logic [PhaseWidth-1:0] ph);
      next_rsp.tx_byte  = b;
      next_rsp.tx_valid = 1'b1;
      seq_phase         = ph;
   endfunction

   function automatic void end_command(input logic [1:0] st);
      next_rsp.done_res = 1'b1;
      next_rsp.status   = st;
      seq_phase         = PH_IDLE;
   endfunction

   // Every ack wait opens with a zero byte; remember where to resume
   function automatic void start_ack(input logic [PhaseWidth-1:0] from);
      ack_return_phase = from;
      send_next(B_ZERO, PH_ACK_ZERO);
   endfunction

   // Advance the shadow sequencer by one accepted beat; give the response it owes
   function automatic rsp_type predict_response(input req_type r);
      logic [7:0] b;
      next_rsp = '0;
      if (r.kind == KIND_START) begin
         // A start always wins, even over a running command
         cur_cmd          = r.command;
         cur_addr         = r.address;
         len_q            = r.count_m1;
         byte_cnt         = '0;
         xsum             = '0;
         poll_cnt         = '0;
         ack_return_phase = PH_IDLE;
         if (r.command == CMD_SYNC) begin
            poll_cnt = 16'd1;
            send_next(B_FRAME, PH_SYNC_POLL);
         end else if (r.command <= CMD_ERASE) begin
            send_next(B_FRAME, PH_HDR_FRAME);
         end else begin
            end_command(ST_UNEXP);
         end
      end else begin
         case (seq_phase)
            PH_SYNC_POLL: begin
               // Sync never retries: anything but the dummy ends it
               if (r.rx_byte == B_DUMMY) start_ack(PH_IDLE);
               else end_command(r.rx_byte == B_NACK ? ST_NACK : ST_UNEXP);
            end
            PH_ACK_ZERO: begin
               if (r.rx_byte == B_DUMMY) begin
                  poll_cnt = 16'd1;
                  send_next(B_DUMMY, PH_ACK_POLL);
               end else begin
                  end_command(ST_UNEXP);
               end
            end
            PH_ACK_POLL: begin
               // Ack takes priority, then keep polling on dummy up to the limit
               if (r.rx_byte == B_ACK) begin
                  send_next(B_ACK, PH_ACK_END);
               end else if (r.rx_byte == B_DUMMY) begin
                  if (poll_cnt >= poll_limit_q) begin
                     end_command(ST_TOUT);
                  end else begin
                     poll_cnt = poll_cnt + 16'd1;
                     send_next(B_DUMMY, PH_ACK_POLL);
                  end
               end else begin
                  end_command(r.rx_byte == B_NACK ? ST_NACK : ST_UNEXP);
               end
            end
            PH_ACK_END: begin
               if (r.rx_byte != B_DUMMY) begin
                  end_command(ST_UNEXP);
               end else begin
                  case (ack_return_phase)
                     PH_HDR_CHK: begin
                        if (cur_cmd == CMD_GET) begin
                           send_next(B_DUMMY, PH_GET_LEAD);
                        end else if (cur_cmd == CMD_READ || cur_cmd == CMD_WRMEM) begin
                           byte_cnt = '0;
                           b        = address_byte_at(0);
                           xsum     = b;
                           send_next(b, PH_ADDR);
                        end else if (cur_cmd == CMD_ERASE) begin
                           send_next(B_ONES, PH_ER_FF1);
                        end else begin
                           end_command(ST_OK);
                        end
                     end
                     PH_ADDR_CHK: begin
                        if (cur_cmd == CMD_READ) begin
                           send_next(len_q, PH_LEN);
                        end else if (cur_cmd == CMD_WRMEM) begin
                           // Write checksum folds the length in first
                           xsum = len_q;
                           send_next(len_q, PH_WR_LEN);
                           next_rsp.payload_wanted = 1'b1;
                        end else begin
                           end_command(ST_OK);
                        end
                     end
                     PH_LEN_CHK: send_next(B_DUMMY, PH_RD_LEAD);
                     PH_ER_FF2:  send_next(B_ZERO, PH_ER_CHK);
                     default:    end_command(ST_OK);
                  endcase
               end
            end
            PH_HDR_FRAME: send_next(header_code(cur_cmd), PH_HDR_CODE);
            PH_HDR_CODE:  send_next(header_code(cur_cmd) ^ B_ONES, PH_HDR_CHK);
            PH_HDR_CHK, PH_ADDR_CHK, PH_LEN_CHK, PH_ER_FF2: start_ack(seq_phase);
            PH_WR_CHK, PH_ER_CHK: start_ack(PH_IDLE);
            PH_ADDR: begin
               if (byte_cnt < 9'd3) begin
                  byte_cnt = byte_cnt + 9'd1;
                  b        = address_byte_at(int'(byte_cnt));
                  xsum     = xsum ^ b;
                  send_next(b, PH_ADDR);
               end else begin
                  send_next(xsum, PH_ADDR_CHK);
               end
            end
            PH_LEN: send_next(len_q ^ B_ONES, PH_LEN_CHK);
            PH_RD_LEAD: begin
               byte_cnt = '0;
               send_next(B_DUMMY, PH_RD_DATA);
            end
            PH_GET_LEAD: send_next(B_DUMMY, PH_GET_LEN);
            PH_GET_LEN: begin
               // The target tells how many bytes follow, minus one
               len_q    = r.rx_byte;
               byte_cnt = '0;
               send_next(B_DUMMY, PH_GET_DATA);
            end
            PH_RD_DATA, PH_GET_DATA: begin
               next_rsp.read_valid = 1'b1;
               next_rsp.read_byte  = r.rx_byte;
               if (byte_cnt >= {1'b0, len_q}) begin
                  if (seq_phase == PH_GET_DATA) start_ack(PH_IDLE);
                  else end_command(ST_OK);
               end else begin
                  byte_cnt = byte_cnt + 9'd1;
                  send_next(B_DUMMY, seq_phase);
               end
            end
            PH_WR_LEN: begin
               byte_cnt = '0;
               xsum     = xsum ^ r.payload_byte;
               send_next(r.payload_byte, PH_WR_DATA);
               next_rsp.payload_wanted = (byte_cnt < {1'b0, len_q});
            end
            PH_WR_DATA: begin
               if (byte_cnt < {1'b0, len_q}) begin
                  byte_cnt = byte_cnt + 9'd1;
                  xsum     = xsum ^ r.payload_byte;
                  send_next(r.payload_byte, PH_WR_DATA);
                  next_rsp.payload_wanted = (byte_cnt < {1'b0, len_q});
               end else begin
                  send_next(xsum, PH_WR_CHK);
               end
            end
            PH_ER_FF1: send_next(B_ONES, PH_ER_FF2);
            // Exchange while idle: ignore, all-zero response
            default: seq_phase = PH_IDLE;
         endcase
      end
      return next_rsp;
   endfunction

   function automatic string rsp_text(input rsp_type x);
      return $sformatf("tx=%h txv=%b pw=%b rv=%b rb=%h done=%b st=%0d", x.tx_byte,
                       x.tx_valid, x.payload_wanted, x.read_valid, x.read_byte,
                       x.done_res, x.status);
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one beat after a random gap; hold valid high on return so that a
   // back-to-back beat never lowers and raises it in the same step.
   task automatic send_beat(input req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= r.kind;
      req_ch.command      <= r.command;
      req_ch.address      <= r.address;
      req_ch.count_m1     <= r.count_m1;
      req_ch.rx_byte      <= r.rx_byte;
      req_ch.payload_byte <= r.payload_byte;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      // Beats that the sequencer ignores do not advance the budget
      if (!(r.kind == KIND_EXCHANGE && seq_phase == PH_IDLE)) beats_sent++;
      pending_responses.push_back(predict_response(r));
   endtask

   task automatic send_start(input logic [2:0] cmd, input logic [31:0] addr,
                             input logic [7:0] len);
      req_type r;
      r.kind         = KIND_START;
      r.command      = cmd;
      r.address      = addr;
      r.count_m1     = len;
      r.rx_byte      = 8'($urandom);
      r.payload_byte = 8'($urandom);
      send_beat(r);
   endtask

   // Fields other than rx and payload are don't-care on an exchange: randomise them
   task automatic send_exchange(input logic [7:0] rx);
      req_type r;
      r.kind         = KIND_EXCHANGE;
      r.command      = 3'($urandom);
      r.address      = $urandom;
      r.count_m1     = 8'($urandom);
      r.rx_byte      = rx;
      r.payload_byte = 8'($urandom);
      send_beat(r);
   endtask

   task automatic idle_req();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and hold the sender until every predicted response is in
   task automatic wait_until_drained();
      idle_req();
      while (pending_responses.size() > 0) @(posedge clock);
   endtask

   // Play the target: answer with what the current phase wants, mostly
   task automatic respond_step();
      int pick;
      logic [7:0] rx;
      pick = $urandom_range(0, 99);
      rx   = 8'($urandom);
      case (seq_phase)
         PH_SYNC_POLL, PH_ACK_ZERO, PH_ACK_END: begin
            if (pick < 95) rx = B_DUMMY;
            else if (pick < 97) rx = B_NACK;
         end
         PH_ACK_POLL: begin
            if (pick < poll_dummy_pct) rx = B_DUMMY;
            else if (pick < 97) rx = B_ACK;
            else if (pick < 98) rx = B_NACK;
         end
         PH_GET_LEN: begin
            if (pick < 90) rx = 8'($urandom_range(0, 7));
         end
         default: ;
      endcase
      send_exchange(rx);
   endtask

   task automatic start_command();
      int pick;
      logic [2:0] cmd;
      logic [31:0] addr;
      logic [7:0] len;
      pick = $urandom_range(0, 99);
      cmd  = (pick < 96) ? 3'($urandom_range(CMD_SYNC, CMD_ERASE)) : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 9);
      addr = (pick == 0) ? '0 : (pick == 1) ? '1 : 32'($urandom);
      // Keep lengths short mostly; the odd full-size transfer
      pick = $urandom_range(0, 99);
      if (pick < 70) len = 8'($urandom_range(0, 3));
      else if (pick < 92) len = 8'($urandom_range(4, 15));
      else if (pick < 97) len = 8'($urandom);
      else len = 8'hFF;
      send_start(cmd, addr, len);
   endtask

   // Converse until the command ends; optionally break off to force a restart
   task automatic finish_conversation(input bit may_abort);
      while (seq_phase != PH_IDLE) begin
         if (may_abort && $urandom_range(0, 299) == 0) return;
         respond_step();
      end
   endtask

   task automatic run_traffic(input int budget);
      int target;
      target = beats_sent + budget;
      while (beats_sent < target) begin
         // Stray exchange between commands now and then
         if (seq_phase == PH_IDLE && $urandom_range(0, 39) == 0) send_exchange(8'($urandom));
         start_command();
         finish_conversation(1'b1);
      end
   endtask

   // Write the limit only with no command running and nothing in flight
   task automatic write_poll_limit(input logic [15:0] value);
      finish_conversation(1'b0);
      wait_until_drained();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      poll_limit_q = value;
      csr_we <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_cases();
      // Exchange with nothing running
      send_exchange(8'hFF);
      // Unknown command codes end at once
      send_start(3'd7, 32'hFFFF_FFFF, 8'hFF);
      send_start(3'd5, 32'h0000_0000, 8'h00);
      // Sync answered with nack, then with junk
      send_start(CMD_SYNC, 32'h0000_0000, 8'h00);
      send_exchange(B_NACK);
      send_start(CMD_SYNC, 32'hFFFF_FFFF, 8'hFF);
      send_exchange(B_ZERO);
      // Wrong byte after the ack zero
      send_start(CMD_SYNC, 32'h1234_5678, 8'h80);
      send_exchange(B_DUMMY);
      send_exchange(B_ACK);
      // Nack while polling
      send_start(CMD_SYNC, 32'h8000_0001, 8'h01);
      send_exchange(B_DUMMY);
      send_exchange(B_DUMMY);
      send_exchange(B_NACK);
      // Restart in the middle of a get, then a clean sync
      send_start(CMD_GET, 32'h5555_AAAA, 8'h7F);
      send_exchange(8'h3C);
      send_start(CMD_SYNC, 32'hAAAA_5555, 8'hFE);
      send_exchange(B_DUMMY);
      send_exchange(B_DUMMY);
      send_exchange(B_ACK);
      send_exchange(B_DUMMY);
      // Junk in place of the closing dummy
      send_start(CMD_SYNC, 32'h0F0F_F0F0, 8'h55);
      send_exchange(B_DUMMY);
      send_exchange(B_DUMMY);
      send_exchange(B_ACK);
      send_exchange(B_NACK);
   endtask

   task automatic test_poll_limits();
      logic [15:0] limits [5];
      limits = '{16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd6};
      // Poll mostly with dummies so that short limits time out
      poll_dummy_pct = 88;
      foreach (limits[i]) begin
         write_poll_limit(limits[i]);
         run_traffic(140);
      end
   endtask

   task automatic test_back_pressure();
      write_poll_limit(POLL_LIMIT_RESET);
      poll_dummy_pct = 60;
      // Stall the receiver for a long stretch and keep offering back-to-back beats
      no_gaps         = 1'b1;
      rsp_hold_cycles = LONG_HOLD;
      run_traffic(80);
      no_gaps = 1'b0;
      // Hold the sender until the pipe is empty, then carry on
      finish_conversation(1'b0);
      wait_until_drained();
      run_traffic(120);
   endtask

   task automatic test_random_traffic();
      for (int round = 0; round < 4; round++) begin
         case (round)
            0:       write_poll_limit(POLL_LIMIT_RESET);
            1:       write_poll_limit(16'($urandom_range(1, 12)));
            2:       write_poll_limit(16'hFFFF);
            default: write_poll_limit(16'($urandom));
         endcase
         poll_dummy_pct = $urandom_range(30, 90);
         run_traffic(200);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin : stimulus
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= KIND_START;
      req_ch.command      <= CMD_SYNC;
      req_ch.address      <= '0;
      req_ch.count_m1     <= '0;
      req_ch.rx_byte      <= '0;
      req_ch.payload_byte <= '0;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;

      poll_limit_q     = POLL_LIMIT_RESET;
      seq_phase        = PH_IDLE;
      ack_return_phase = PH_IDLE;
      cur_cmd          = CMD_SYNC;
      cur_addr         = '0;
      byte_cnt         = '0;
      len_q            = '0;
      xsum             = '0;
      poll_cnt         = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_poll_limits();
      test_back_pressure();
      test_random_traffic();

      finish_conversation(1'b0);
      wait_until_drained();
      // Let any stray response show up before judging
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_responses.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: random stalls, one long hold on request, and checking
   // ------------------------------------------------------------------
   initial begin : response_checker
      int      stall;
      rsp_type got;
      rsp_type want;
      rsp_ch.ready <= 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            stall = draw_gap();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);

         got.tx_byte        = rsp_ch.tx_byte;
         got.tx_valid       = rsp_ch.tx_valid;
         got.payload_wanted = rsp_ch.payload_wanted;
         got.read_valid     = rsp_ch.read_valid;
         got.read_byte      = rsp_ch.read_byte;
         got.done_res       = rsp_ch.done_res;
         got.status         = rsp_ch.status;

         if (pending_responses.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: response beat with none predicted: %s", $realtime, rsp_text(got));
         end else begin
            want = pending_responses.pop_front();
            if (got.tx_byte !== want.tx_byte || got.tx_valid !== want.tx_valid ||
                got.payload_wanted !== want.payload_wanted ||
                got.read_valid !== want.read_valid || got.read_byte !== want.read_byte ||
                got.done_res !== want.done_res || got.status !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: mismatch, expected %s, actual %s", $realtime,
                           rsp_text(want), rsp_text(got));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: drop out if neither channel moves a beat for too long
   // ------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

endmodule
